[rtl/tmeu_pkg.sv]
// Shared types and constants for the tape machine execute unit.
// No dependencies; used by tmeu_tape and tape_machine_execute_unit.
package tmeu_pkg;

	localparam int TAPE_DEPTH    = 65536;
	localparam int PROGRAM_DEPTH = 65536;
	localparam int TAPE_AW       = $clog2(TAPE_DEPTH);
	localparam int PC_W          = 16;
	localparam int CELL_W        = 8;

	// The machine stops once the program counter reaches this position.
	localparam logic [PC_W-1:0] HALT_PC = PC_W'(PROGRAM_DEPTH - 1);

	typedef enum logic [2:0] {
		CMD_RIGHT = 3'd0,
		CMD_LEFT  = 3'd1,
		CMD_INC   = 3'd2,
		CMD_DEC   = 3'd3,
		CMD_OPEN  = 3'd4,
		CMD_CLOSE = 3'd5,
		CMD_READ  = 3'd6,
		CMD_WRITE = 3'd7
	} cmd_t;

	// One executed request as seen by the tape.
	typedef struct packed {
		logic               exec;
		cmd_t               cmd;
		logic [CELL_W-1:0]  wdata;
		logic [TAPE_AW-1:0] addr;
		logic [TAPE_AW-1:0] nxt_addr;
	} tape_op_t;

endpackage

[rtl/tmeu_tape.sv]
// Byte tape: synchronous memory, current-cell register and the clearing pass.
// Depends on tmeu_pkg.
module tmeu_tape (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tmeu_pkg::tape_op_t         op,
	output logic [tmeu_pkg::CELL_W-1:0] cur_cell,
	output logic                       busy
);

	logic [tmeu_pkg::CELL_W-1:0]  mem [tmeu_pkg::TAPE_DEPTH];
	logic [tmeu_pkg::CELL_W-1:0]  rd_data_s1;
	logic [tmeu_pkg::CELL_W-1:0]  cur_q;
	logic                         rd_sel_q;
	logic                         clearing_q;
	logic [tmeu_pkg::TAPE_AW-1:0] clr_q;

	logic [tmeu_pkg::CELL_W-1:0]  new_cell;
	logic                         is_wr;
	logic                         is_mv;
	logic                         mem_we;
	logic [tmeu_pkg::TAPE_AW-1:0] mem_wa;
	logic [tmeu_pkg::CELL_W-1:0]  mem_wd;

	// After a pointer move the cell comes straight from the memory read port;
	// otherwise the register holds the current cell, including fresh writes.
	assign cur_cell = rd_sel_q ? rd_data_s1 : cur_q;
	assign busy     = clearing_q;

	always_comb begin
		is_wr    = 1'b0;
		is_mv    = 1'b0;
		new_cell = cur_cell;
		case (op.cmd)
			tmeu_pkg::CMD_INC: begin
				new_cell = cur_cell + 8'd1;
				is_wr    = op.exec;
			end
			tmeu_pkg::CMD_DEC: begin
				new_cell = cur_cell - 8'd1;
				is_wr    = op.exec;
			end
			tmeu_pkg::CMD_READ: begin
				new_cell = op.wdata;
				is_wr    = op.exec;
			end
			tmeu_pkg::CMD_RIGHT, tmeu_pkg::CMD_LEFT: begin
				is_mv = op.exec;
			end
			default: begin
				new_cell = cur_cell;
			end
		endcase

		if (clearing_q) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else begin
			mem_we = is_wr;
			mem_wa = op.addr;
			mem_wd = new_cell;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (is_mv) begin
			rd_data_s1 <= mem[op.nxt_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			cur_q <= '0;
		end else if (is_wr) begin
			cur_q <= new_cell;
		end else begin
			cur_q <= cur_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_sel_q   <= 1'b0;
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else begin
			rd_sel_q <= is_mv;
			if (clearing_q) begin
				clr_q <= clr_q + tmeu_pkg::TAPE_AW'(1);
				if (clr_q == tmeu_pkg::TAPE_AW'(tmeu_pkg::TAPE_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
		end
	end

	// The tape takes no request while it is being cleared.
	a_no_exec_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !op.exec)
		else $error("tape request during clearing pass");

	// A write to the current cell is visible to the next request.
	a_write_visible: assert property (@(posedge clk) disable iff (!arst_n)
		is_wr |=> cur_cell == $past(new_cell))
		else $error("written cell value not forwarded");

	// Read data is selected only in the cycle after a move.
	a_rd_sel_after_move: assert property (@(posedge clk) disable iff (!arst_n)
		rd_sel_q |-> $past(is_mv))
		else $error("read data selected without a move");

endmodule

[rtl/tape_machine_execute_unit.sv]
// A result is registered and valid in the cycle after its request is accepted.
// Throughput: one request per cycle; cmd_ready stays high while the tape is not
// clearing and the result register is free or is being emptied in the same cycle.
// Reset: pointer and program counter go to zero, then a clearing pass over all
// TAPE_DEPTH (65536) cells zeroes the tape with cmd_ready held low.
// Depends on tmeu_pkg and tmeu_tape.
module tape_machine_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [2:0]  command,
	input  logic [15:0] match_target,
	input  logic [7:0]  input_char,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [15:0] next_pc,
	output logic        out_valid,
	output logic [7:0]  out_char,
	output logic        halted
);

	logic [tmeu_pkg::PC_W-1:0]   pc_q;
	logic [15:0]                 ptr_q;
	logic                        res_valid_q;
	logic [tmeu_pkg::PC_W-1:0]   next_pc_q;
	logic                        out_valid_q;
	logic [tmeu_pkg::CELL_W-1:0] out_char_q;
	logic                        halted_q;

	tmeu_pkg::cmd_t              cmd;
	tmeu_pkg::tape_op_t          tape_op;
	logic [tmeu_pkg::CELL_W-1:0] cur_cell;
	logic                        busy;
	logic                        accept;
	logic                        halt_now;
	logic                        exec;
	logic [15:0]                 ptr_nxt;
	logic [tmeu_pkg::PC_W-1:0]   pc_nxt;
	logic                        emit;

	assign cmd       = tmeu_pkg::cmd_t'(command);
	assign cmd_ready = !busy && (!res_valid_q || res_ready);
	assign accept    = cmd_valid && cmd_ready;
	assign halt_now  = pc_q >= tmeu_pkg::HALT_PC;
	assign exec      = accept && !halt_now;
	assign emit      = exec && (cmd == tmeu_pkg::CMD_WRITE);

	always_comb begin
		ptr_nxt = ptr_q;
		pc_nxt  = pc_q + 16'd1;
		case (cmd)
			tmeu_pkg::CMD_RIGHT: ptr_nxt = ptr_q + 16'd1;
			tmeu_pkg::CMD_LEFT:  ptr_nxt = ptr_q - 16'd1;
			tmeu_pkg::CMD_OPEN: begin
				if (cur_cell == '0) begin
					pc_nxt = match_target;
				end
			end
			tmeu_pkg::CMD_CLOSE: begin
				if (cur_cell != '0) begin
					pc_nxt = match_target;
				end
			end
			default: begin
				ptr_nxt = ptr_q;
			end
		endcase
		// A halted machine ignores the request and reports where it stopped.
		if (halt_now) begin
			pc_nxt = pc_q;
		end
	end

	always_comb begin
		tape_op.exec     = exec;
		tape_op.cmd      = cmd;
		tape_op.wdata    = input_char;
		tape_op.addr     = ptr_q[tmeu_pkg::TAPE_AW-1:0];
		tape_op.nxt_addr = ptr_nxt[tmeu_pkg::TAPE_AW-1:0];
	end

	tmeu_tape u_tape (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (tape_op),
		.cur_cell (cur_cell),
		.busy     (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			ptr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pc_q        <= pc_nxt;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (exec) begin
				ptr_q <= ptr_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			next_pc_q   <= pc_nxt;
			out_valid_q <= emit;
			out_char_q  <= emit ? cur_cell : '0;
			halted_q    <= pc_nxt >= tmeu_pkg::HALT_PC;
		end
	end

	assign res_valid = res_valid_q;
	assign next_pc   = next_pc_q;
	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign halted    = halted_q;

	// No request is taken while the tape is being cleared.
	a_idle_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd_ready)
		else $error("request accepted during clearing pass");

	// Once halted, the program counter and pointer stay put.
	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		halt_now |=> $stable(pc_q) && $stable(ptr_q))
		else $error("state changed while halted");

	// A right move advances the pointer by exactly one.
	a_right_step: assert property (@(posedge clk) disable iff (!arst_n)
		exec && cmd == tmeu_pkg::CMD_RIGHT |=> ptr_q == $past(ptr_q) + 16'd1)
		else $error("pointer did not advance on right move");

	// The reported program counter matches the architectural one.
	a_pc_reported: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> next_pc_q == pc_q)
		else $error("result program counter mismatch");

endmodule
